>>> sv/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared widths, register indexes, channel payloads and state types for the
// structured box mesh generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbm_pkg;

	// Field and datapath widths
	localparam int CNT_W     = 11;              // cell or vertex count per axis
	localparam int PRD_W     = 2 * CNT_W;       // product of two axis counts
	localparam int DIV_W     = PRD_W + CNT_W;   // dividend and shifted divisor
	localparam int IDX_W     = 31;
	localparam int SPC_W     = 32;
	localparam int CRD_W     = 42;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int STEP_W    = $clog2(CNT_W);
	localparam int QUE_DEPTH = 2;
	localparam int QPTR_W    = $clog2(QUE_DEPTH);
	localparam int QCNT_W    = $clog2(QUE_DEPTH + 1);

	localparam int DEF_MAX_CELLS = 1024;

	// Request kinds
	localparam logic FUNC_VERTEX  = 1'b0;
	localparam logic FUNC_ELEMENT = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z  = 3'd6;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] entity_index;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_id;
		logic [CRD_W-1:0] coord_x;
		logic [CRD_W-1:0] coord_y;
		logic [CRD_W-1:0] coord_z;
		logic             last_result;
		logic             index_error;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       dimensions;
		logic [CNT_W-1:0] cells_x;
		logic [CNT_W-1:0] cells_y;
		logic [CNT_W-1:0] cells_z;
		logic [SPC_W-1:0] spacing_x;
		logic [SPC_W-1:0] spacing_y;
		logic [SPC_W-1:0] spacing_z;
	} cfg_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic             func;
		logic             err;
		logic [1:0]       dim;
		logic [CNT_W-1:0] i;
		logic [CNT_W-1:0] j;
		logic [CNT_W-1:0] k;
		logic [CNT_W-1:0] nvx;
		logic [PRD_W-1:0] nvxy;
	} job_t;

	// Queue handshake status seen by both sides
	typedef struct packed {
		logic push;
		logic full;
		logic pop;
		logic avail;
	} que_ctl_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_PREP,
		F_CHK,
		F_DIVK,
		F_DIVJ,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_SUM,
		B_EMIT
	} back_state_t;

	// Force a cell count into 1 .. maxc
	function automatic logic [CNT_W-1:0] clamp_cells(logic [CNT_W-1:0] c,
		logic [CNT_W-1:0] maxc);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (c > maxc) begin
			r = maxc;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/sbm_chan_if.sv
// ----------------------------------------------------------------------------
// sbm_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbm_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sbm_front.sv
// ----------------------------------------------------------------------------
// sbm_front
// Takes requests, checks the index against the entity count and splits it
// into axis indices with a bit-serial divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_front #(
	parameter int MAX_CELLS = sbm_pkg::DEF_MAX_CELLS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sbm_pkg::in_item_t in_data,
	input  wire sbm_pkg::cfg_t     cfg,
	output logic                   push,
	input  wire logic              full,
	output sbm_pkg::job_t          push_data
);
	localparam int CNT_W  = sbm_pkg::CNT_W;
	localparam int PRD_W  = sbm_pkg::PRD_W;
	localparam int DIV_W  = sbm_pkg::DIV_W;
	localparam int IDX_W  = sbm_pkg::IDX_W;
	localparam int STEP_W = sbm_pkg::STEP_W;
	localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_CELLS);

	sbm_pkg::front_state_t state_q, state_d;

	logic                 hold_v_q;
	sbm_pkg::in_item_t    hold_q;
	logic                 take;

	logic                 func_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PRD_W-1:0]     d1_q;
	logic [CNT_W-1:0]     d2_q;
	logic [CNT_W-1:0]     lim_q;
	logic [CNT_W-1:0]     nvx_q;
	logic [PRD_W-1:0]     nvxy_q;
	logic [1:0]           dim_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dsh_q;
	logic [CNT_W-1:0]     quo_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     j_q;
	logic [STEP_W-1:0]    step_q;
	logic                 err_q;

	// Axis counts from the registers
	logic [1:0]           dim;
	logic [CNT_W-1:0]     nx, ny, nz, nvx, nvy, nvz;
	logic [PRD_W-1:0]     nvxy, nxy;

	// Divider step
	logic                 ge;
	logic [DIV_W-1:0]     rem_n;
	logic [CNT_W-1:0]     quo_n;
	logic                 ovf;
	logic                 step_last;

	// Input holding register
	assign in_ready = !hold_v_q;
	assign take     = (state_q == sbm_pkg::F_IDLE) && hold_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			hold_v_q <= 1'b1;
		end else if (take) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_q <= in_data;
		end
	end

	// Normalise dimension and cell counts
	always_comb begin
		dim  = (cfg.dimensions == 2'd0) ? 2'd1 : cfg.dimensions;
		nx   = sbm_pkg::clamp_cells(cfg.cells_x, MAXC);
		ny   = (dim >= 2'd2) ? sbm_pkg::clamp_cells(cfg.cells_y, MAXC) : CNT_W'(1);
		nz   = (dim == 2'd3) ? sbm_pkg::clamp_cells(cfg.cells_z, MAXC) : CNT_W'(1);
		nvx  = nx + CNT_W'(1);
		nvy  = (dim >= 2'd2) ? ny + CNT_W'(1) : CNT_W'(1);
		nvz  = (dim == 2'd3) ? nz + CNT_W'(1) : CNT_W'(1);
		nvxy = PRD_W'(nvx) * PRD_W'(nvy);
		nxy  = PRD_W'(nx) * PRD_W'(ny);
	end

	// Restoring division, one quotient bit per cycle
	always_comb begin
		ge        = rem_q >= dsh_q;
		rem_n     = ge ? rem_q - dsh_q : rem_q;
		quo_n     = {quo_q[CNT_W-2:0], ge};
		ovf       = (32'(idx_q) >> CNT_W) >= 32'(d1_q);
		step_last = step_q == '0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			sbm_pkg::F_IDLE: begin
				if (take) begin
					state_d = sbm_pkg::F_PREP;
				end
			end
			sbm_pkg::F_PREP: state_d = sbm_pkg::F_CHK;
			sbm_pkg::F_CHK: begin
				state_d = ovf ? sbm_pkg::F_PUSH : sbm_pkg::F_DIVK;
			end
			sbm_pkg::F_DIVK: begin
				if (step_last) begin
					state_d = (quo_n >= lim_q) ? sbm_pkg::F_PUSH : sbm_pkg::F_DIVJ;
				end
			end
			sbm_pkg::F_DIVJ: begin
				if (step_last) begin
					state_d = sbm_pkg::F_PUSH;
				end
			end
			sbm_pkg::F_PUSH: begin
				push = !full;
				if (!full) begin
					state_d = sbm_pkg::F_IDLE;
				end
			end
			default: state_d = sbm_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbm_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sbm_pkg::F_IDLE: begin
				func_q <= hold_q.func;
				idx_q  <= hold_q.entity_index;
				err_q  <= 1'b0;
			end
			sbm_pkg::F_PREP: begin
				d1_q   <= (func_q == sbm_pkg::FUNC_ELEMENT) ? nxy : nvxy;
				d2_q   <= (func_q == sbm_pkg::FUNC_ELEMENT) ? nx : nvx;
				lim_q  <= (func_q == sbm_pkg::FUNC_ELEMENT) ? nz : nvz;
				nvx_q  <= nvx;
				nvxy_q <= nvxy;
				dim_q  <= dim;
			end
			sbm_pkg::F_CHK: begin
				err_q  <= ovf;
				rem_q  <= DIV_W'(idx_q);
				dsh_q  <= DIV_W'(d1_q) << (CNT_W - 1);
				quo_q  <= '0;
				step_q <= STEP_W'(CNT_W - 1);
			end
			sbm_pkg::F_DIVK: begin
				rem_q  <= rem_n;
				quo_q  <= quo_n;
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - STEP_W'(1);
				if (step_last) begin
					k_q    <= quo_n;
					err_q  <= quo_n >= lim_q;
					quo_q  <= '0;
					dsh_q  <= DIV_W'(d2_q) << (CNT_W - 1);
					step_q <= STEP_W'(CNT_W - 1);
				end
			end
			sbm_pkg::F_DIVJ: begin
				rem_q  <= rem_n;
				quo_q  <= quo_n;
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - STEP_W'(1);
				if (step_last) begin
					j_q <= quo_n;
				end
			end
			default: begin
			end
		endcase
	end

	// Job payload; the remainder left after the second division is i
	always_comb begin
		push_data      = '0;
		push_data.func = func_q;
		push_data.err  = err_q;
		push_data.dim  = dim_q;
		push_data.i    = rem_q[CNT_W-1:0];
		push_data.j    = j_q;
		push_data.k    = k_q;
		push_data.nvx  = nvx_q;
		push_data.nvxy = nvxy_q;
	end
endmodule

`default_nettype wire

>>> sv/sbm_queue.sv
// ----------------------------------------------------------------------------
// sbm_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sbm_pkg::job_t     wr_data,
	output sbm_pkg::job_t          rd_data,
	input  wire sbm_pkg::que_ctl_t ctl_in,
	output logic                   full,
	output logic                   avail
);
	localparam int QPTR_W = sbm_pkg::QPTR_W;
	localparam int QCNT_W = sbm_pkg::QCNT_W;

	sbm_pkg::job_t     mem_q [sbm_pkg::QUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full    = cnt_q == QCNT_W'(sbm_pkg::QUE_DEPTH);
	assign avail   = cnt_q != '0;
	assign do_push = ctl_in.push && !full;
	assign do_pop  = ctl_in.pop && avail;
	assign rd_data = mem_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_data;
		end
	end
endmodule

`default_nettype wire

>>> sv/sbm_back.sv
// ----------------------------------------------------------------------------
// sbm_back
// Carries out one job: coordinates for a vertex, or the corner vertex ids of
// an element, one beat per cycle when not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          avail,
	input  wire sbm_pkg::job_t job,
	output logic               pop,
	input  wire sbm_pkg::cfg_t cfg,
	output logic               out_valid,
	input  wire logic          out_ready,
	output sbm_pkg::out_item_t out_data
);
	localparam int CNT_W = sbm_pkg::CNT_W;
	localparam int DIV_W = sbm_pkg::DIV_W;
	localparam int PRD_W = sbm_pkg::PRD_W;
	localparam int IDX_W = sbm_pkg::IDX_W;
	localparam int CRD_W = sbm_pkg::CRD_W;
	localparam int MUL_W = sbm_pkg::SPC_W + CNT_W;

	sbm_pkg::back_state_t state_q, state_d;

	sbm_pkg::job_t       job_q;
	logic [DIV_W-1:0]    p1_q;
	logic [PRD_W-1:0]    p2_q;
	logic [MUL_W-1:0]    cx_q, cy_q, cz_q;
	logic [IDX_W-1:0]    base_q;
	logic [2:0]          c_q;
	logic                ov_q;
	sbm_pkg::out_item_t  out_q;

	logic                load;
	logic [2:0]          c_last;
	logic                is_last;
	logic                di, dj, dk;
	logic [IDX_W-1:0]    vid;
	sbm_pkg::out_item_t  beat;

	assign pop       = (state_q == sbm_pkg::B_IDLE) && avail;
	assign load      = (state_q == sbm_pkg::B_EMIT) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign out_data  = out_q;

	// Corner offsets and the beat to emit
	always_comb begin
		unique case (job_q.dim)
			2'd1:    c_last = 3'd1;
			2'd2:    c_last = 3'd3;
			default: c_last = 3'd7;
		endcase
		if (job_q.dim == 2'd1) begin
			di = c_q[0];
			dj = 1'b0;
			dk = 1'b0;
		end else begin
			di = c_q[1:0] == 2'd1 || c_q[1:0] == 2'd2;
			dj = c_q[1];
			dk = c_q[2];
		end
		vid = base_q + (dk ? IDX_W'(job_q.nvxy) : '0) + (dj ? IDX_W'(job_q.nvx) : '0)
			+ IDX_W'(di);
		is_last = job_q.err || (job_q.func == sbm_pkg::FUNC_VERTEX) || (c_q == c_last);

		beat             = '0;
		beat.last_result = is_last;
		if (job_q.err) begin
			beat.index_error = 1'b1;
		end else if (job_q.func == sbm_pkg::FUNC_VERTEX) begin
			beat.coord_x = CRD_W'(cx_q);
			beat.coord_y = (job_q.dim >= 2'd2) ? CRD_W'(cy_q) : '0;
			beat.coord_z = (job_q.dim == 2'd3) ? CRD_W'(cz_q) : '0;
		end else begin
			beat.vertex_id = vid;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbm_pkg::B_IDLE: begin
				if (avail) begin
					state_d = sbm_pkg::B_MUL;
				end
			end
			sbm_pkg::B_MUL: state_d = sbm_pkg::B_SUM;
			sbm_pkg::B_SUM: state_d = sbm_pkg::B_EMIT;
			sbm_pkg::B_EMIT: begin
				if (load && is_last) begin
					state_d = sbm_pkg::B_IDLE;
				end
			end
			default: state_d = sbm_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbm_pkg::B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Products, base id and corner count
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (state_q == sbm_pkg::B_MUL) begin
			p1_q <= DIV_W'(job_q.k) * DIV_W'(job_q.nvxy);
			p2_q <= PRD_W'(job_q.j) * PRD_W'(job_q.nvx);
			cx_q <= MUL_W'(job_q.i) * MUL_W'(cfg.spacing_x);
			cy_q <= MUL_W'(job_q.j) * MUL_W'(cfg.spacing_y);
			cz_q <= MUL_W'(job_q.k) * MUL_W'(cfg.spacing_z);
		end
		if (state_q == sbm_pkg::B_SUM) begin
			base_q <= IDX_W'(p1_q + DIV_W'(p2_q) + DIV_W'(job_q.i));
			c_q    <= '0;
		end
		if (load) begin
			out_q <= beat;
			c_q   <= c_q + 3'd1;
		end
	end
endmodule

`default_nettype wire

>>> sv/structured_box_mesh_generator.sv
// ----------------------------------------------------------------------------
// structured_box_mesh_generator
// Uniform box mesh in one to three dimensions: vertex coordinates or element
// corner vertex ids for a requested index.
// ----------------------------------------------------------------------------
//  channel   dir   payload              beats per item
//  in_ch     in    func, entity_index   1
//  out_ch    out   id, coords, flags    1 (vertex, error) or 2/4/8 (element)
//  cfg_*     in    register write       -
//
//  The front works through one request at a time; its bit-serial divider
//  produces one quotient bit a cycle for each of up to two divisions.
//  The back sets up a job, then gives one beat a cycle while out_ch is ready.
//  A two-entry job queue sits between the two, and an input holding register
//  takes the next request while the front is busy. Reset clears control
//  state and loads the register defaults; stalls on out_ch hold the back,
//  and once the job queue fills they hold the front and then in_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module structured_box_mesh_generator #(
	parameter int MAX_CELLS_PER_AXIS = sbm_pkg::DEF_MAX_CELLS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sbm_chan_if.sink                           in_ch,
	sbm_chan_if.source                         out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [sbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sbm_pkg::CFG_DAT_W-1:0] cfg_data
);
	localparam int CNT_W = sbm_pkg::CNT_W;
	localparam int SPC_W = sbm_pkg::SPC_W;

	sbm_pkg::cfg_t     cfg_q;
	sbm_pkg::job_t     push_data, pop_data;
	sbm_pkg::que_ctl_t qctl;
	logic              q_push, q_pop, q_full, q_avail;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dimensions <= 2'd3;
			cfg_q.cells_x    <= CNT_W'(1);
			cfg_q.cells_y    <= CNT_W'(1);
			cfg_q.cells_z    <= CNT_W'(1);
			cfg_q.spacing_x  <= SPC_W'(65536);
			cfg_q.spacing_y  <= SPC_W'(65536);
			cfg_q.spacing_z  <= SPC_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbm_pkg::CFG_DIMENSIONS: cfg_q.dimensions <= cfg_data[1:0];
				sbm_pkg::CFG_CELLS_X:    cfg_q.cells_x    <= cfg_data[CNT_W-1:0];
				sbm_pkg::CFG_CELLS_Y:    cfg_q.cells_y    <= cfg_data[CNT_W-1:0];
				sbm_pkg::CFG_CELLS_Z:    cfg_q.cells_z    <= cfg_data[CNT_W-1:0];
				sbm_pkg::CFG_SPACING_X:  cfg_q.spacing_x  <= cfg_data[SPC_W-1:0];
				sbm_pkg::CFG_SPACING_Y:  cfg_q.spacing_y  <= cfg_data[SPC_W-1:0];
				sbm_pkg::CFG_SPACING_Z:  cfg_q.spacing_z  <= cfg_data[SPC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sbm_front #(
		.MAX_CELLS (MAX_CELLS_PER_AXIS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_data   (in_ch.data),
		.cfg       (cfg_q),
		.push      (q_push),
		.full      (q_full),
		.push_data (push_data)
	);

	always_comb begin
		qctl.push  = q_push;
		qctl.full  = q_full;
		qctl.pop   = q_pop;
		qctl.avail = q_avail;
	end

	sbm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (push_data),
		.rd_data (pop_data),
		.ctl_in  (qctl),
		.full    (q_full),
		.avail   (q_avail)
	);

	sbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.job       (pop_data),
		.pop       (q_pop),
		.cfg       (cfg_q),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);

`ifndef SYNTH
	// Front never pushes into a full queue
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		!(qctl.push && qctl.full))
		else $error("job pushed into full queue");

	// Back never pops an empty queue
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> qctl.avail)
		else $error("job popped from empty queue");

	// An error beat ends its request and carries no id
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.index_error) |->
			(out_ch.data.last_result && out_ch.data.vertex_id == '0))
		else $error("error beat not final or carries an id");
`endif
endmodule

`default_nettype wire
